>>> hdl/vfc_pkg.sv
// Shared constants and types for the view frustum cull unit.
package vfc_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned PlaneCount = 6;
  localparam int unsigned AccWidth   = 100;

  typedef enum logic [2:0] {
    OpLoad  = 3'd0,
    OpBuild = 3'd1,
    OpPoint = 3'd2,
    OpSphere = 3'd3,
    OpCube  = 3'd4,
    OpBox   = 3'd5,
    OpRsvd6 = 3'd6,
    OpRsvd7 = 3'd7
  } op_e;

  // Saturate a 33-bit signed value to a signed word.
  function automatic logic signed [WordWidth-1:0] sat_word(input logic signed [WordWidth:0] v);
    logic signed [WordWidth-1:0] r;
    begin
      if (v[WordWidth] != v[WordWidth-1]) begin
        r = v[WordWidth] ? {1'b1, {(WordWidth-1){1'b0}}} : {1'b0, {(WordWidth-1){1'b1}}};
      end else begin
        r = v[WordWidth-1:0];
      end
      return r;
    end
  endfunction

endpackage

>>> hdl/vfc_divsqrt.sv
// Bit-serial unit: integer square root of a wide value, or unsigned division.
module vfc_divsqrt (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         sqrt_i,
  input  logic [99:0]  num_i,
  input  logic [63:0]  den_i,
  output logic         done_o,
  output logic [63:0]  res_o
);

  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [99:0] num_q, num_d;
  logic [65:0] rem_q, rem_d;
  logic [63:0] res_q, res_d;
  logic [63:0] den_q, den_d;
  logic        sqrt_q, sqrt_d;
  logic        done_q, done_d;
  logic [65:0] trial;
  logic [65:0] shifted;

  // Sqrt consumes two bits a step (50 steps); divide takes the low 52 numerator bits,
  // one a step (52 steps).
  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    rem_d   = rem_q;
    res_d   = res_q;
    den_d   = den_q;
    sqrt_d  = sqrt_q;
    done_d  = 1'b0;
    trial   = '0;
    shifted = '0;
    if (start_i) begin
      busy_d = 1'b1;
      sqrt_d = sqrt_i;
      num_d  = sqrt_i ? num_i : {num_i[51:0], 48'd0};
      den_d  = den_i;
      rem_d  = '0;
      res_d  = '0;
      cnt_d  = sqrt_i ? 7'd50 : 7'd52;
    end else if (busy_q) begin
      if (sqrt_q) begin
        shifted = {rem_q[63:0], num_q[99:98]};
        trial   = {res_q[63:0], 2'b01};
        num_d   = {num_q[97:0], 2'b00};
        if (shifted >= trial) begin
          rem_d = shifted - trial;
          res_d = {res_q[62:0], 1'b1};
        end else begin
          rem_d = shifted;
          res_d = {res_q[62:0], 1'b0};
        end
      end else begin
        shifted = {rem_q[64:0], num_q[99]};
        num_d   = {num_q[98:0], 1'b0};
        if (shifted >= {2'b00, den_q}) begin
          rem_d = shifted - {2'b00, den_q};
          res_d = {res_q[62:0], 1'b1};
        end else begin
          rem_d = shifted;
          res_d = {res_q[62:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      sqrt_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
      sqrt_q <= sqrt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    res_q <= res_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> hdl/view_frustum_cull_test.sv
// View frustum cull unit: top level with plane build and shape query sequencer.
// A build forms 6 planes of 4 coefficients from sums and differences of matrix
// entries, and with normalization adds per plane three squares, a square root and four
// divides. A point or sphere query tests one plane at a time; a cube or box query tests
// one corner at a time, up to 8 corners per plane, stopping at the first plane that
// culls. The build sums use adders; squares and dot products go through one 33x33
// multiplier feeding a 100-bit accumulator, plus the bit-serial root/divide unit.
module view_frustum_cull_test (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [3:0]  matrix_index_i,
  input  logic signed [31:0] matrix_value_i,
  input  logic signed [31:0] px_i,
  input  logic signed [31:0] py_i,
  input  logic signed [31:0] pz_i,
  input  logic [30:0] extent_i,
  input  logic signed [31:0] qx_i,
  input  logic signed [31:0] qy_i,
  input  logic signed [31:0] qz_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        inside_res_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StBSum  = 4'd1;
  localparam logic [3:0] StBSq   = 4'd2;
  localparam logic [3:0] StBRoot = 4'd3;
  localparam logic [3:0] StBDivS = 4'd4;
  localparam logic [3:0] StBDivW = 4'd5;
  localparam logic [3:0] StQMac  = 4'd6;
  localparam logic [3:0] StQEval = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;
  localparam logic [3:0] StBRootW = 4'd9;
  localparam int unsigned PlaneCountArr = vfc_pkg::PlaneCount * 4;

  logic [3:0] state_q, state_d;
  logic       norm_q;
  logic [31:0] matrix_mem [16];
  logic signed [31:0] plane_q [PlaneCountArr];

  logic [2:0]  op_q;
  logic signed [32:0] lo_q [3];
  logic signed [32:0] hi_q [3];
  logic [30:0] ext_q;
  logic [2:0]  pl_q, pl_d;
  logic [2:0]  cor_q, cor_d;
  logic [2:0]  term_q, term_d;
  logic [1:0]  k_q, k_d;
  logic [99:0] acc_q, acc_d;
  logic        res_q, res_d;
  logic [63:0] len_q;
  logic signed [31:0] ma_q, mb_q;
  logic        sq_start, sq_sqrt, sq_done;
  logic [99:0] sq_num;
  logic [63:0] sq_res;

  // multiplier operands
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic [4:0]  pidx;
  logic signed [32:0] coord;
  logic        in_acc, out_acc;
  logic signed [31:0] div_v;
  logic [31:0] div_mag;
  logic [63:0] qlim;
  logic signed [31:0] div_r;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (state_q == StOut);
  assign inside_res_o = res_q;

  assign pidx = 5'({2'b00, pl_q} * 5'd4) + 5'(k_q);

  always_comb begin
    unique case (term_q[1:0])
      2'd0:    coord = cor_q[0] ? hi_q[0] : lo_q[0];
      2'd1:    coord = cor_q[1] ? hi_q[1] : lo_q[1];
      2'd2:    coord = cor_q[2] ? hi_q[2] : lo_q[2];
      default: coord = 33'sd0;
    endcase
  end

  always_comb begin
    mul_a = 33'(plane_q[5'({2'b00, pl_q} * 5'd4) + 5'(term_q[1:0])]);
    mul_b = coord;
    if (state_q == StBSq) begin
      mul_a = 33'(plane_q[5'({2'b00, pl_q} * 5'd4) + 5'(term_q[1:0])]);
      mul_b = mul_a;
    end else if (term_q == 3'd3) begin
      // d plus sphere bias, both scaled by 2^FracBits
      mul_a = 33'(plane_q[5'({2'b00, pl_q} * 5'd4) + 5'd3]) + 33'({2'b00, ext_q});
      mul_b = 33'sd65536;
    end
    mul_p = 66'(mul_a) * 66'(mul_b);
  end

  // Normalize division: sign of the input and saturation of the result
  assign div_v   = plane_q[pidx];
  assign div_mag = div_v[31] ? 32'(-div_v) : 32'(div_v);
  assign qlim  = div_v[31] ? 64'h8000_0000 : 64'h7FFF_FFFF;
  always_comb begin
    if (sq_res > qlim) begin
      div_r = div_v[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      div_r = div_v[31] ? 32'(-$signed({1'b0, sq_res[31:0]})) : $signed(sq_res[31:0]);
    end
  end

  always_comb begin
    sq_start = 1'b0;
    sq_sqrt  = 1'b0;
    sq_num   = acc_q;
    if (state_q == StBRoot) begin
      sq_start = 1'b1;
      sq_sqrt  = 1'b1;
    end else if (state_q == StBDivS) begin
      // magnitude scaled by 2^FracBits
      sq_start = 1'b1;
      sq_num   = {52'd0, div_mag, 16'd0};
    end
  end

  vfc_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .sqrt_i (sq_sqrt),
    .num_i  (sq_num),
    .den_i  (len_q),
    .done_o (sq_done),
    .res_o  (sq_res)
  );

  always_comb begin
    state_d = state_q;
    pl_d = pl_q; cor_d = cor_q; term_d = term_q; k_d = k_q;
    acc_d = acc_q; res_d = res_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          pl_d = '0; cor_d = '0; term_d = '0; k_d = '0; acc_d = '0;
          res_d = 1'b1;
          unique case (operation_i)
            vfc_pkg::OpBuild: state_d = StBSum;
            vfc_pkg::OpPoint, vfc_pkg::OpSphere, vfc_pkg::OpCube, vfc_pkg::OpBox:
              state_d = StQMac;
            default: state_d = StIdle;
          endcase
        end
      end
      StBSum: begin
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          if (norm_q) begin
            state_d = StBSq; term_d = '0; acc_d = '0;
          end else if (pl_q == 3'd5) begin
            state_d = StIdle;
          end else begin
            pl_d = pl_q + 3'd1;
          end
        end
      end
      StBSq: begin
        acc_d = acc_q + 100'(mul_p);
        term_d = term_q + 3'd1;
        if (term_q == 3'd2) state_d = StBRoot;
      end
      StBRoot: state_d = StBRootW;
      StBRootW: begin
        if (sq_done) begin
          k_d = '0;
          if (sq_res == 64'd0) begin
            if (pl_q == 3'd5) state_d = StIdle;
            else begin pl_d = pl_q + 3'd1; state_d = StBSum; end
          end else begin
            state_d = StBDivS;
          end
        end
      end
      StBDivS: state_d = StBDivW;
      StBDivW: begin
        if (sq_done) begin
          k_d = k_q + 2'd1;
          if (k_q == 2'd3) begin
            k_d = '0;
            if (pl_q == 3'd5) state_d = StIdle;
            else begin pl_d = pl_q + 3'd1; state_d = StBSum; end
          end else begin
            state_d = StBDivS;
          end
        end
      end
      StQMac: begin
        acc_d  = acc_q + {{34{mul_p[65]}}, mul_p};
        term_d = term_q + 3'd1;
        if (term_q == 3'd3) state_d = StQEval;
      end
      StQEval: begin
        acc_d = '0; term_d = '0;
        if (!acc_q[99] && (acc_q != '0)) begin
          // corner or point on the inner side: plane passes
          cor_d = '0;
          if (pl_q == 3'd5) state_d = StOut;
          else begin pl_d = pl_q + 3'd1; state_d = StQMac; end
        end else if ((op_q == vfc_pkg::OpCube || op_q == vfc_pkg::OpBox) && cor_q != 3'd7) begin
          cor_d = cor_q + 3'd1; state_d = StQMac;
        end else begin
          res_d = 1'b0; state_d = StOut;
        end
      end
      StOut: if (out_acc) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      norm_q  <= 1'b0;
      for (int i = 0; i < PlaneCountArr; i++) plane_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) norm_q <= cfg_data_i;
      if (state_q == StBSum) begin
        plane_q[pidx] <= vfc_pkg::sat_word(
          (pl_q == 3'd5) ? 33'(mb_q) :
          (pl_q == 3'd1 || pl_q == 3'd2) ? 33'(ma_q) + 33'(mb_q) : 33'(ma_q) - 33'(mb_q));
      end else if (state_q == StBDivW && sq_done) begin
        plane_q[pidx] <= div_r;
      end
    end
  end

  logic [1:0] col_sel;
  always_comb begin
    unique case (pl_d)
      3'd0, 3'd1: col_sel = 2'd0;
      3'd2, 3'd3: col_sel = 2'd1;
      default:    col_sel = 2'd2;
    endcase
  end

  always_ff @(posedge clk_i) begin
    pl_q <= pl_d; cor_q <= cor_d; term_q <= term_d; k_q <= k_d;
    acc_q <= acc_d; res_q <= res_d;
    if (state_q == StBRootW && sq_done) len_q <= sq_res;
    if (in_acc && operation_i == vfc_pkg::OpLoad) matrix_mem[matrix_index_i] <= matrix_value_i;
    // matrix fetch for the next build step
    ma_q <= matrix_mem[{k_d, 2'd3}];
    mb_q <= matrix_mem[{k_d, col_sel}];
    if (in_acc) begin
      op_q  <= operation_i;
      ext_q <= (operation_i == vfc_pkg::OpSphere) ? extent_i : 31'd0;
      if (operation_i == vfc_pkg::OpCube) begin
        lo_q[0] <= 33'(px_i) - 33'(extent_i); hi_q[0] <= 33'(px_i) + 33'(extent_i);
        lo_q[1] <= 33'(py_i) - 33'(extent_i); hi_q[1] <= 33'(py_i) + 33'(extent_i);
        lo_q[2] <= 33'(pz_i) - 33'(extent_i); hi_q[2] <= 33'(pz_i) + 33'(extent_i);
      end else begin
        lo_q[0] <= 33'(px_i); hi_q[0] <= 33'(qx_i);
        lo_q[1] <= 33'(py_i); hi_q[1] <= 33'(qy_i);
        lo_q[2] <= 33'(pz_i); hi_q[2] <= 33'(qz_i);
      end
    end
  end

  // Fetch the entries for the next sum step ahead, registered from the next row and plane.

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(inside_res_o))
    else $error("result dropped while stalled");
  a_not_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o)
    else $error("ready while busy");
  a_plane_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (pl_q <= 3'd5))
    else $error("plane index out of range");

endmodule
